/* sv/vss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vss_pkg
// Types and constants shared by the valve stroke sequencer modules.
// ----------------------------------------------------------------------------
package vss_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_REVERSE_THRESHOLD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DIRECTION_DELAY   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_INERTIA_DELAY     = 2'd2;

  // Configuration reset values.
  localparam logic [14:0] RST_REVERSE_THRESHOLD = 15'd100;
  localparam logic [15:0] RST_DIRECTION_DELAY   = 16'd500;
  localparam logic [15:0] RST_INERTIA_DELAY     = 16'd500;

  // Phase codes.
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_FORWARD = 3'd1;
  localparam logic [2:0] PH_REVERSE = 3'd2;
  localparam logic [2:0] PH_FINAL   = 3'd3;
  localparam logic [2:0] PH_FAILURE = 3'd4;
  localparam logic [2:0] PH_STOPPED = 3'd5;

  // Current in mA at which the forward stroke ends.
  localparam logic signed [15:0] FORWARD_TRIP_MA = 16'sd65;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_START  = 1'b1;

  typedef struct packed {
    logic              func;
    logic [31:0]       now_ms;
    logic signed [15:0] sample_ma;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic        drive_enable;
    logic        drive_forward;
    logic        done_res;
    logic        passed;
    logic [31:0] forward_ms;
    logic [31:0] reverse_ms;
    logic [31:0] final_ms;
  } out_item_t;

  typedef struct packed {
    logic [14:0] reverse_threshold_ma;
    logic [15:0] direction_delay_ms;
    logic [15:0] inertia_delay_ms;
  } cfg_t;

endpackage

/* sv/vss_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vss_cfg_regs
// Configuration register bank written through a plain write port.
// ----------------------------------------------------------------------------
module vss_cfg_regs import vss_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_REVERSE_THRESHOLD: cfg_d.reverse_threshold_ma = cfg_data_i[14:0];
        CFG_DIRECTION_DELAY:   cfg_d.direction_delay_ms   = cfg_data_i;
        CFG_INERTIA_DELAY:     cfg_d.inertia_delay_ms     = cfg_data_i;
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reverse_threshold_ma <= RST_REVERSE_THRESHOLD;
      cfg_q.direction_delay_ms   <= RST_DIRECTION_DELAY;
      cfg_q.inertia_delay_ms     <= RST_INERTIA_DELAY;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

/* sv/vss_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vss_step
// Phase state and the combinational evaluation of one word.
// ----------------------------------------------------------------------------
module vss_step import vss_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     fire_i,
  input  wire in_item_t item_i,
  input  wire cfg_t     cfg_i,
  output out_item_t     result_o
);

  logic [2:0]  phase_q, phase_d;
  logic [31:0] change_q, change_d;
  logic [31:0] start_q, start_d;
  logic [31:0] fwd_dur_q, fwd_dur_d;
  logic [31:0] rev_dur_q, rev_dur_d;
  logic [31:0] fin_dur_q, fin_dur_d;
  logic        drv_en_q, drv_en_d;
  logic        drv_fwd_q, drv_fwd_d;
  logic        done;

  logic [31:0] elapsed;
  logic [31:0] since_start;
  logic [16:0] long_delay;
  logic        short_ok;
  logic        long_ok;
  logic        fwd_trip;
  logic        thr_trip;

  assign elapsed     = item_i.now_ms - change_q;
  assign since_start = item_i.now_ms - start_q;
  assign long_delay  = {1'b0, cfg_i.direction_delay_ms} + {1'b0, cfg_i.inertia_delay_ms};
  assign short_ok    = elapsed >= {16'd0, cfg_i.direction_delay_ms};
  assign long_ok     = elapsed >= {15'd0, long_delay};
  assign fwd_trip    = item_i.sample_ma >= FORWARD_TRIP_MA;
  assign thr_trip    = item_i.sample_ma >= $signed({1'b0, cfg_i.reverse_threshold_ma});

  always_comb begin
    phase_d   = phase_q;
    change_d  = change_q;
    start_d   = start_q;
    fwd_dur_d = fwd_dur_q;
    rev_dur_d = rev_dur_q;
    fin_dur_d = fin_dur_q;
    drv_en_d  = drv_en_q;
    drv_fwd_d = drv_fwd_q;
    done      = 1'b0;
    if (item_i.func == FUNC_START) begin
      // A start restarts the stroke from any phase.
      phase_d   = PH_FORWARD;
      change_d  = item_i.now_ms;
      start_d   = item_i.now_ms;
      drv_en_d  = 1'b1;
      drv_fwd_d = 1'b1;
    end else begin
      unique case (phase_q)
        PH_FORWARD: begin
          if (short_ok && fwd_trip) begin
            phase_d   = PH_REVERSE;
            change_d  = item_i.now_ms;
            start_d   = item_i.now_ms;
            fwd_dur_d = since_start;
            drv_en_d  = 1'b1;
            drv_fwd_d = 1'b0;
          end
        end
        PH_REVERSE: begin
          if (long_ok && thr_trip) begin
            phase_d   = PH_FINAL;
            change_d  = item_i.now_ms;
            start_d   = item_i.now_ms;
            rev_dur_d = since_start;
            drv_en_d  = 1'b1;
            drv_fwd_d = 1'b1;
          end
        end
        PH_FINAL: begin
          // The direction line is left as it was when the drive turns off.
          if (long_ok && thr_trip) begin
            phase_d   = PH_STOPPED;
            fin_dur_d = since_start;
            drv_en_d  = 1'b0;
            done      = 1'b1;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      change_q  <= '0;
      start_q   <= '0;
      fwd_dur_q <= '0;
      rev_dur_q <= '0;
      fin_dur_q <= '0;
      drv_en_q  <= 1'b0;
      drv_fwd_q <= 1'b0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      change_q  <= change_d;
      start_q   <= start_d;
      fwd_dur_q <= fwd_dur_d;
      rev_dur_q <= rev_dur_d;
      fin_dur_q <= fin_dur_d;
      drv_en_q  <= drv_en_d;
      drv_fwd_q <= drv_fwd_d;
    end
  end

  always_comb begin
    result_o.phase         = phase_d;
    result_o.drive_enable  = drv_en_d;
    result_o.drive_forward = drv_fwd_d;
    result_o.done_res      = done;
    result_o.passed        = (phase_d == PH_STOPPED);
    result_o.forward_ms    = fwd_dur_d;
    result_o.reverse_ms    = rev_dur_d;
    result_o.final_ms      = fin_dur_d;
  end

`ifndef NO_ASSERTIONS
  // The failure phase is never entered by this sequencer.
  a_no_failure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_FAILURE)
    else $error("vss_step: failure phase reached");

  // A completed stroke always leaves the drive off.
  a_stop_drive_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_STOPPED) |-> !drv_en_q)
    else $error("vss_step: drive on while stopped");

  // State only moves on an evaluated word.
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(phase_q) && $stable(change_q))
    else $error("vss_step: state changed without a word");
`endif

endmodule
`default_nettype wire

/* sv/valve_stroke_sequencer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// valve_stroke_sequencer
// Forward, reverse and final stroke sequencer with phase duration capture.
// ----------------------------------------------------------------------------
// The block takes one word per clock and returns one result word for each:
// the word is held in an input register, the phase logic evaluates it
// combinationally against the stored phase state, and the result lands in
// an output register. A stall on the output holds both registers, so a
// sustained stall backs up to in_stall_o; otherwise a new word is taken
// every cycle. Configuration writes take effect at the next clock edge and
// should be made while no word is in flight.
// ----------------------------------------------------------------------------
module valve_stroke_sequencer import vss_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_item_t            in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_item_t                out_item_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_vld_q;
  out_item_t out_q;
  logic      out_vld_q;
  out_item_t result;
  logic      fire;
  logic      out_free;
  logic      in_take;

  vss_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  vss_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  assign out_free   = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_item_i;
    end
    if (fire) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

`ifndef NO_ASSERTIONS
  // Every evaluated word shows up in the output register next cycle.
  a_fire_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_vld_q)
    else $error("valve_stroke_sequencer: evaluated word lost");

  // The input side only stalls when a word is waiting in the input register.
  a_stall_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q && out_vld_q)
    else $error("valve_stroke_sequencer: stall without a pending word");

  // The completion word always reports a pass with the drive off.
  a_done_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.done_res) |-> (out_q.passed && !out_q.drive_enable))
    else $error("valve_stroke_sequencer: done without pass");
`endif

endmodule
`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the valve stroke sequencer. A queue-fed driver
// sends timestamped current words, a monitor predicts the stroke phase,
// drive lines and captured durations of each word, and compares them field
// by field with the result words. Directed words cover the phase boundaries
// and timestamp wrap, random strokes run under several register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import vss_pkg::*;

  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned LONG_HOLD = 60;
  localparam int unsigned WORDS_PER_SETTING = 200;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_item;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = CFG_REVERSE_THRESHOLD;
  logic [CfgDataW-1:0] cfg_data = '0;

  valve_stroke_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  // Register copies used by the predictor.
  logic [14:0] thr_cfg = RST_REVERSE_THRESHOLD;
  logic [15:0] dir_cfg = RST_DIRECTION_DELAY;
  logic [15:0] inert_cfg = RST_INERTIA_DELAY;

  // Predicted sequencer state.
  logic [2:0]  seq_phase = PH_IDLE;
  logic [31:0] seq_change_ms = '0;
  logic [31:0] seq_start_ms = '0;
  logic [31:0] seq_fwd_ms = '0;
  logic [31:0] seq_rev_ms = '0;
  logic [31:0] seq_fin_ms = '0;
  logic        seq_drv_en = 1'b0;
  logic        seq_drv_fwd = 1'b0;

  in_item_t  word_q[$];
  out_item_t stroke_status_q[$];
  int        word_cnt = 0;
  int        status_cnt = 0;
  int        error_cnt = 0;
  int        quiet_cycles = 0;
  int        send_gap = 0;
  int        stall_gap = 0;
  int        hold_left = 0;
  logic      in_taken = 1'b0;
  logic      no_idle = 1'b0;
  logic      long_hold_go = 1'b0;
  logic      long_hold_done = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_error(string msg);
    if (error_cnt < 50) $display("ERROR @%0t: %s", $time, msg);
    error_cnt++;
  endtask

  function automatic out_item_t advance_stroke(in_item_t w);
    logic [31:0] elapsed;
    logic [31:0] long_blank;
    int          cur_ma;
    int          thr_ma;
    int          trip_ma;
    logic        done;
    out_item_t   r;
    elapsed = w.now_ms - seq_change_ms;
    // The two delays add without overflow; both are zero-extended first.
    long_blank = 32'(dir_cfg) + 32'(inert_cfg);
    cur_ma = $signed(w.sample_ma);
    thr_ma = int'(thr_cfg);
    trip_ma = FORWARD_TRIP_MA;
    done = 1'b0;
    if (w.func == FUNC_START) begin
      seq_phase = PH_FORWARD;
      seq_start_ms = w.now_ms;
      seq_change_ms = w.now_ms;
      seq_drv_en = 1'b1;
      seq_drv_fwd = 1'b1;
    end else begin
      case (seq_phase)
        PH_FORWARD: begin
          if (elapsed >= 32'(dir_cfg) && cur_ma >= trip_ma) begin
            seq_drv_en = 1'b1;
            seq_drv_fwd = 1'b0;
            seq_phase = PH_REVERSE;
            seq_change_ms = w.now_ms;
            seq_fwd_ms = w.now_ms - seq_start_ms;
            seq_start_ms = w.now_ms;
          end
        end
        PH_REVERSE: begin
          if (elapsed >= long_blank && cur_ma >= thr_ma) begin
            seq_drv_en = 1'b1;
            seq_drv_fwd = 1'b1;
            seq_phase = PH_FINAL;
            seq_change_ms = w.now_ms;
            seq_rev_ms = w.now_ms - seq_start_ms;
            seq_start_ms = w.now_ms;
          end
        end
        PH_FINAL: begin
          // The direction line is left forward when the motor stops.
          if (elapsed >= long_blank && cur_ma >= thr_ma) begin
            seq_drv_en = 1'b0;
            seq_phase = PH_STOPPED;
            seq_fin_ms = w.now_ms - seq_start_ms;
            done = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    r.phase = seq_phase;
    r.drive_enable = seq_drv_en;
    r.drive_forward = seq_drv_fwd;
    r.done_res = done;
    r.passed = (seq_phase == PH_STOPPED);
    r.forward_ms = seq_fwd_ms;
    r.reverse_ms = seq_rev_ms;
    r.final_ms = seq_fin_ms;
    return r;
  endfunction

  // Monitor: results are checked before the new expectation is queued so that
  // a result can never match the word taken on the same edge.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (stroke_status_q.size() == 0) begin
          report_error($sformatf("result %0d arrived with nothing expected", status_cnt));
        end else begin
          want = stroke_status_q.pop_front();
          if (out_item.phase !== want.phase)
            report_error($sformatf("result %0d phase %0d, expected %0d",
                                   status_cnt, out_item.phase, want.phase));
          if (out_item.drive_enable !== want.drive_enable)
            report_error($sformatf("result %0d drive_enable %b, expected %b",
                                   status_cnt, out_item.drive_enable, want.drive_enable));
          if (out_item.drive_forward !== want.drive_forward)
            report_error($sformatf("result %0d drive_forward %b, expected %b",
                                   status_cnt, out_item.drive_forward, want.drive_forward));
          if (out_item.done_res !== want.done_res)
            report_error($sformatf("result %0d done_res %b, expected %b",
                                   status_cnt, out_item.done_res, want.done_res));
          if (out_item.passed !== want.passed)
            report_error($sformatf("result %0d passed %b, expected %b",
                                   status_cnt, out_item.passed, want.passed));
          if (out_item.forward_ms !== want.forward_ms)
            report_error($sformatf("result %0d forward_ms %0d, expected %0d",
                                   status_cnt, out_item.forward_ms, want.forward_ms));
          if (out_item.reverse_ms !== want.reverse_ms)
            report_error($sformatf("result %0d reverse_ms %0d, expected %0d",
                                   status_cnt, out_item.reverse_ms, want.reverse_ms));
          if (out_item.final_ms !== want.final_ms)
            report_error($sformatf("result %0d final_ms %0d, expected %0d",
                                   status_cnt, out_item.final_ms, want.final_ms));
        end
        status_cnt++;
      end
      if (in_valid && !in_stall) stroke_status_q.push_back(advance_stroke(in_item));
    end
    in_taken <= rst_ni && in_valid && !in_stall;
  end

  // Driver: a word is held until it is taken, then the next one is offered
  // unless an idle burst starts.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      in_valid <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 9) == 0) begin
      send_gap <= $urandom_range(0, 6);
      in_valid <= 1'b0;
    end else if (word_q.size() != 0) begin
      in_item <= word_q.pop_front();
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver stall: short random bursts plus one long hold-off that lets the
  // block back up into its input.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (long_hold_go && !long_hold_done) begin
      long_hold_done <= 1'b1;
      hold_left <= LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (stall_gap > 0) begin
      stall_gap <= stall_gap - 1;
      out_stall <= 1'b1;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      stall_gap <= $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic queue_word(logic func, logic [31:0] now, logic [15:0] cur);
    in_item_t w;
    w.func = func;
    w.now_ms = now;
    w.sample_ma = cur;
    word_q.push_back(w);
    word_cnt++;
  endtask

  task automatic wait_drained();
    while (word_q.size() != 0 || in_valid || stroke_status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_REVERSE_THRESHOLD: thr_cfg = val[14:0];
      CFG_DIRECTION_DELAY:   dir_cfg = val;
      CFG_INERTIA_DELAY:     inert_cfg = val;
      default: begin
      end
    endcase
  endtask

  task automatic apply_setting(logic [14:0] thr, logic [15:0] dir, logic [15:0] inert);
    write_reg(CFG_REVERSE_THRESHOLD, {1'b0, thr});
    write_reg(CFG_DIRECTION_DELAY, dir);
    write_reg(CFG_INERTIA_DELAY, inert);
  endtask

  // Currents cluster around the forward trip and the reverse threshold.
  function automatic logic [15:0] pick_current();
    int c;
    int lo;
    lo = (int'(thr_cfg) > 65) ? int'(thr_cfg) : 65;
    case ($urandom_range(0, 9))
      0, 1: c = $urandom_range(0, 65535);
      2: c = 64 + $urandom_range(0, 2);
      3: begin
        c = int'(thr_cfg) - 1 + $urandom_range(0, 2);
        if (c > 32767) c = 32767;
      end
      4, 5, 6: c = int'($urandom_range(0, 64)) - 40;
      default: c = $urandom_range(lo, 32767);
    endcase
    return c[15:0];
  endfunction

  task automatic gen_stroke();
    logic [31:0] t;
    int          n;
    int unsigned lim;
    lim = (32'(dir_cfg) + 32'(inert_cfg)) / 4 + 2;
    n = $urandom_range(12, 40);
    if ($urandom_range(0, 9) == 0) begin
      repeat (n) begin
        queue_word(($urandom_range(0, 7) == 0) ? FUNC_START : FUNC_SAMPLE,
                   $urandom(), 16'($urandom_range(0, 65535)));
      end
    end else begin
      t = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000) : $urandom();
      queue_word(FUNC_START, t, pick_current());
      repeat (n) begin
        // An occasional jump anywhere exercises wrapped elapsed times.
        if ($urandom_range(0, 19) == 0) t = $urandom();
        else t = t + $urandom_range(0, lim);
        if ($urandom_range(0, 39) == 0) queue_word(FUNC_START, t, pick_current());
        else queue_word(FUNC_SAMPLE, t, pick_current());
      end
    end
  endtask

  task automatic run_strokes(int n);
    int first;
    first = word_cnt;
    while (word_cnt - first < n) begin
      gen_stroke();
      if ($urandom_range(0, 11) == 0) wait_drained();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: idle samples, exact forward delay and trip boundaries,
    // a wrapped forward stroke, restarts from idle, forward, reverse, stopped.
    queue_word(FUNC_SAMPLE, 32'h0000_0000, 16'h7FFF);
    queue_word(FUNC_SAMPLE, 32'hFFFF_FFFF, 16'h8000);
    queue_word(FUNC_START,  32'hFFFF_FF00, 16'h0000);
    queue_word(FUNC_SAMPLE, 32'hFFFF_FF00 + 32'd499, 16'h7FFF);
    queue_word(FUNC_SAMPLE, 32'hFFFF_FF00 + 32'd500, 16'd64);
    queue_word(FUNC_SAMPLE, 32'hFFFF_FF00 + 32'd500, 16'd65);
    queue_word(FUNC_SAMPLE, 32'h0000_00F4 + 32'd999, 16'h7FFF);
    queue_word(FUNC_SAMPLE, 32'h0000_00F4 + 32'd1000, 16'd99);
    queue_word(FUNC_SAMPLE, 32'h0000_00F4 + 32'd1000, 16'd100);
    queue_word(FUNC_SAMPLE, 32'h0000_04DC + 32'd1000, 16'hFFFF);
    queue_word(FUNC_SAMPLE, 32'h0000_04DC + 32'd1200, 16'd100);
    queue_word(FUNC_SAMPLE, 32'h0000_04DC + 32'd6200, 16'h7FFF);
    queue_word(FUNC_START,  32'h0000_1000, 16'h8000);
    // Timestamp one below the start: elapsed wraps to its maximum.
    queue_word(FUNC_SAMPLE, 32'h0000_0FFF, 16'd65);
    queue_word(FUNC_START,  32'h8000_0000, 16'd100);
    queue_word(FUNC_SAMPLE, 32'h8000_0000, 16'h7FFF);
    queue_word(FUNC_START,  32'h7FFF_FFFF, 16'h7FFF);
    queue_word(FUNC_SAMPLE, 32'h8000_0400, 16'h8000);
    wait_drained();

    apply_setting(15'd0, 16'd0, 16'd0);
    run_strokes(WORDS_PER_SETTING);
    wait_drained();

    apply_setting(15'h7FFF, 16'hFFFF, 16'hFFFF);
    run_strokes(WORDS_PER_SETTING);
    @(posedge clk_i);
    long_hold_go = 1'b1;
    wait_drained();

    apply_setting(15'd65, 16'd1, 16'hFFFF);
    run_strokes(WORDS_PER_SETTING);
    wait_drained();

    apply_setting(15'($urandom_range(0, 32767)), 16'($urandom_range(0, 2000)),
                  16'($urandom_range(0, 2000)));
    run_strokes(WORDS_PER_SETTING);
    wait_drained();

    apply_setting(15'($urandom_range(0, 300)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 300)));
    run_strokes(WORDS_PER_SETTING);
    wait_drained();

    // Closing stretch runs at full rate on both sides.
    @(posedge clk_i);
    no_idle = 1'b1;
    apply_setting(RST_REVERSE_THRESHOLD, RST_DIRECTION_DELAY, RST_INERTIA_DELAY);
    run_strokes(WORDS_PER_SETTING);
    wait_drained();

    if (error_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/vss_pkg.sv
sv/vss_cfg_regs.sv
sv/vss_step.sv
sv/valve_stroke_sequencer.sv
verif/tb_top.sv
